// File: hw/rtl/ota_image_receiver_top_defines.svh
// ----------------------------------------------------------------------------
// OTA image receiver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OTA_IMAGE_RECEIVER_TOP_DEFINES_SVH
`define OTA_IMAGE_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication.
`define OTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ota_rx_pkg.sv
// ----------------------------------------------------------------------------
// OTA receiver package
// Field widths, codes, CRC constants and divider handshake types.
// ----------------------------------------------------------------------------
package ota_rx_pkg;

  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int WORD_W   = 32;
  localparam int LEN_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LEVEL_W  = 6;
  localparam int TMO_W    = 16;
  localparam int IDLE_W   = 17;
  localparam int CIDX_W   = 1;

  // Divider: quotient never exceeds the progress scale (40), so 6 bits.
  localparam int QUOT_W = 6;
  localparam int NUM_W  = WORD_W + QUOT_W;

  localparam logic [LEN_W-1:0]    PAYLOAD_MAX   = 8'd192;
  localparam logic [WORD_W-1:0]   CRC_PRESET    = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0]   CRC_POLY      = 32'hEDB8_8320;
  localparam logic [IDLE_W-1:0]   IDLE_MAX      = 17'h1_FFFF;
  localparam logic [TMO_W-1:0]    TIMEOUT_RESET = 16'd15000;
  localparam logic [LEVEL_W-1:0]  LEVEL_BASE    = 6'd8;

  typedef enum logic [OP_W-1:0] {
    OP_HEADER = 2'd0,
    OP_BYTE   = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BEGIN_FAIL = 3'd1,
    ST_NO_SESSION = 3'd2,
    ST_DATA_REJ   = 3'd3,
    ST_END_REJ    = 3'd4,
    ST_TIMEOUT    = 3'd5
  } status_e;

  typedef enum logic {
    EV_ACK     = 1'b0,
    EV_TIMEOUT = 1'b1
  } event_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_NODE_ID = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_e;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: hw/rtl/ota_rx_if.sv
// ----------------------------------------------------------------------------
// OTA receiver channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface ota_rx_in_if;
  logic                              valid;
  logic                              ready;
  logic [ota_rx_pkg::OP_W-1:0]       op;
  logic [ota_rx_pkg::KIND_W-1:0]     pkt_kind;
  logic [ota_rx_pkg::WORD_W-1:0]     dest_node;
  logic [ota_rx_pkg::WORD_W-1:0]     offset;
  logic [ota_rx_pkg::LEN_W-1:0]      payload_len;
  logic [ota_rx_pkg::WORD_W-1:0]     image_size;
  logic [ota_rx_pkg::WORD_W-1:0]     image_crc;
  logic                              storage_ok;
  logic [ota_rx_pkg::BYTE_W-1:0]     payload_byte;

  modport source (output valid, op, pkt_kind, dest_node, offset, payload_len,
                  image_size, image_crc, storage_ok, payload_byte, input ready);
  modport sink   (input valid, op, pkt_kind, dest_node, offset, payload_len,
                  image_size, image_crc, storage_ok, payload_byte, output ready);
endinterface

interface ota_rx_out_if;
  logic                              valid;
  logic                              ready;
  logic                              event_res;
  logic [ota_rx_pkg::STATUS_W-1:0]   status;
  logic [ota_rx_pkg::KIND_W-1:0]     echo_kind;
  logic [ota_rx_pkg::WORD_W-1:0]     ack_offset;
  logic [ota_rx_pkg::WORD_W-1:0]     bytes_written;
  logic [ota_rx_pkg::LEVEL_W-1:0]    progress_level;
  logic                              flash_abort;
  logic                              restart;

  modport source (output valid, event_res, status, echo_kind, ack_offset, bytes_written,
                  progress_level, flash_abort, restart, input ready);
  modport sink   (input valid, event_res, status, echo_kind, ack_offset, bytes_written,
                  progress_level, flash_abort, restart, output ready);
endinterface

interface ota_rx_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ota_rx_pkg::CIDX_W-1:0]     index;
  logic [ota_rx_pkg::WORD_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ota_rx_div.sv
// ----------------------------------------------------------------------------
// OTA receiver progress divider
// Restoring divider, one quotient bit per cycle, for quotients below 64.
// ----------------------------------------------------------------------------
module ota_rx_div (
  input  logic                 clk,
  input  logic                 rst,
  input  ota_rx_pkg::div_req_t req,
  output ota_rx_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(ota_rx_pkg::QUOT_W);

  logic [ota_rx_pkg::NUM_W-1:0]  rem;
  logic [ota_rx_pkg::NUM_W-1:0]  dsh;
  logic [ota_rx_pkg::QUOT_W-1:0] quot;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic                          done;
  logic                          fits;

  assign fits     = (rem >= dsh);
  assign rsp.done = done;
  assign rsp.quot = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.num;
        // divisor aligned to the top quotient bit
        dsh  <= {{(ota_rx_pkg::NUM_W - ota_rx_pkg::WORD_W){1'b0}}, req.den}
                << (ota_rx_pkg::QUOT_W - 1);
        quot <= '0;
        cnt  <= CNT_W'(ota_rx_pkg::QUOT_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quot <= {quot[ota_rx_pkg::QUOT_W-2:0], fits};
        dsh  <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/ota_image_receiver_top.sv
// ----------------------------------------------------------------------------
// OTA image receiver
// Session control, CRC-32 and progress for the receive side of an image transfer.
// ----------------------------------------------------------------------------
// One item is handled at a time. A payload byte that a data header announced
// passes through the accept cycle and eight steps of the bit-serial CRC-32
// register. An accepted data header passes through accept, divider load,
// six steps of the one-bit-per-cycle divider that forms the progress level,
// one step to collect the quotient and one to load the result register.
// Other headers and ticks that give a result pass through accept and result
// load; those that give none end at accept. The result sits in an output
// register, so the next item is taken while an earlier result still waits;
// an item whose own result is due holds in its final cycle until that
// register is free. Register writes are taken on every cycle and should
// only be made while the block is idle. There is no clearing pass after reset.
`include "ota_image_receiver_top_defines.svh"

module ota_image_receiver_top (
  input  logic                clk,
  input  logic                rst,
  ota_rx_cfg_if.sink          cfg,
  ota_rx_in_if.sink           rx,
  ota_rx_out_if.source        ack
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_DIVGO,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                              event_res;
    logic [ota_rx_pkg::STATUS_W-1:0]   status;
    logic [ota_rx_pkg::KIND_W-1:0]     echo_kind;
    logic [ota_rx_pkg::WORD_W-1:0]     ack_offset;
    logic [ota_rx_pkg::WORD_W-1:0]     bytes_written;
    logic [ota_rx_pkg::LEVEL_W-1:0]    progress_level;
    logic                              flash_abort;
    logic                              restart;
  } res_t;

  // Registers
  logic [ota_rx_pkg::WORD_W-1:0] node_id;
  logic [ota_rx_pkg::TMO_W-1:0]  timeout_ms;

  // Session state
  logic                          session_open;
  logic [ota_rx_pkg::WORD_W-1:0] expected_size;
  logic [ota_rx_pkg::WORD_W-1:0] expected_crc;
  logic [ota_rx_pkg::WORD_W-1:0] written_count;
  logic [ota_rx_pkg::WORD_W-1:0] running_crc;
  logic [ota_rx_pkg::IDLE_W-1:0] idle_ms;
  logic [ota_rx_pkg::LEN_W-1:0]  bytes_left;

  state_t state;
  logic [2:0] bit_cnt;           // CRC bit step within a byte
  res_t pend;                    // result being built
  res_t out_res;                 // result on offer
  logic out_valid;

  ota_rx_pkg::div_req_t div_req;
  ota_rx_pkg::div_rsp_t div_rsp;

  // Decode of the item on offer
  logic                          accept;
  logic                          hdr_drop;
  logic                          begin_dup;
  logic                          begin_fail;
  logic                          data_dup;
  logic                          data_bad;
  logic                          end_ok;
  logic [ota_rx_pkg::WORD_W:0]   data_end;
  logic [ota_rx_pkg::WORD_W:0]   wr_sum;
  logic [ota_rx_pkg::IDLE_W-1:0] idle_inc;
  logic                          tick_expire;
  logic [ota_rx_pkg::WORD_W-1:0] crc_shift;
  logic                          emit_free;

  // --------------------------------------------------------------------------
  // Progress divider: written * 40 / size, quotient 0..40
  // --------------------------------------------------------------------------
  assign div_req.start = (state == S_DIVGO);
  assign div_req.num   = ({{(ota_rx_pkg::QUOT_W){1'b0}}, written_count} << 5)
                       + ({{(ota_rx_pkg::QUOT_W){1'b0}}, written_count} << 3);
  assign div_req.den   = expected_size;

  ota_rx_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;
  assign rx.ready  = (state == S_IDLE);
  assign accept    = rx.valid && rx.ready;
  assign emit_free = !out_valid || ack.ready;

  assign ack.valid          = out_valid;
  assign ack.event_res      = out_res.event_res;
  assign ack.status         = out_res.status;
  assign ack.echo_kind      = out_res.echo_kind;
  assign ack.ack_offset     = out_res.ack_offset;
  assign ack.bytes_written  = out_res.bytes_written;
  assign ack.progress_level = out_res.progress_level;
  assign ack.flash_abort    = out_res.flash_abort;
  assign ack.restart        = out_res.restart;

  // --------------------------------------------------------------------------
  // Header checks; sums kept one bit wider so they never wrap
  // --------------------------------------------------------------------------
  always_comb begin
    hdr_drop   = (rx.dest_node != node_id) || (rx.payload_len > ota_rx_pkg::PAYLOAD_MAX);
    begin_dup  = session_open && (rx.image_size == expected_size)
              && (rx.image_crc == expected_crc) && (written_count == '0);
    begin_fail = (rx.image_size == '0) || !rx.storage_ok;
    data_end   = {1'b0, rx.offset} + {{(ota_rx_pkg::WORD_W + 1 - ota_rx_pkg::LEN_W){1'b0}},
                                      rx.payload_len};
    wr_sum     = {1'b0, written_count}
               + {{(ota_rx_pkg::WORD_W + 1 - ota_rx_pkg::LEN_W){1'b0}}, rx.payload_len};
    data_dup   = (rx.offset < written_count) && (data_end <= {1'b0, written_count});
    data_bad   = (rx.payload_len == '0) || (rx.offset != written_count)
              || (wr_sum > {1'b0, expected_size}) || !rx.storage_ok;
    end_ok     = (written_count == expected_size) && rx.storage_ok
              && ((expected_crc == '0) || ((running_crc ^ ota_rx_pkg::CRC_PRESET)
                                           == expected_crc));
    idle_inc   = (idle_ms == ota_rx_pkg::IDLE_MAX) ? idle_ms : idle_ms + 1'b1;
    tick_expire = session_open && (idle_inc > {1'b0, timeout_ms});
    crc_shift  = running_crc[0] ? ((running_crc >> 1) ^ ota_rx_pkg::CRC_POLY)
                                : (running_crc >> 1);
  end

  // --------------------------------------------------------------------------
  // Sequencer, session state and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id       <= '0;
      timeout_ms    <= ota_rx_pkg::TIMEOUT_RESET;
      session_open  <= 1'b0;
      expected_size <= '0;
      expected_crc  <= '0;
      written_count <= '0;
      running_crc   <= ota_rx_pkg::CRC_PRESET;
      idle_ms       <= '0;
      bytes_left    <= '0;
      state         <= S_IDLE;
      bit_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          ota_rx_pkg::REG_NODE_ID: node_id    <= cfg.data;
          ota_rx_pkg::REG_TIMEOUT: timeout_ms <= cfg.data[ota_rx_pkg::TMO_W-1:0];
        endcase
      end

      if (ack.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // common result fields; the arms below fill the rest
            pend.event_res      <= ota_rx_pkg::EV_ACK;
            pend.status         <= ota_rx_pkg::ST_OK;
            pend.echo_kind      <= rx.pkt_kind;
            pend.ack_offset     <= rx.offset;
            pend.bytes_written  <= written_count;
            pend.progress_level <= '0;
            pend.flash_abort    <= 1'b0;
            pend.restart        <= 1'b0;
            unique case (rx.op)
              ota_rx_pkg::OP_BYTE: begin
                if (bytes_left != '0) begin
                  running_crc <= running_crc
                               ^ {{(ota_rx_pkg::WORD_W - ota_rx_pkg::BYTE_W){1'b0}},
                                  rx.payload_byte};
                  bytes_left  <= bytes_left - 1'b1;
                  bit_cnt     <= '0;
                  state       <= S_CRC;
                end
              end
              ota_rx_pkg::OP_TICK: begin
                idle_ms <= idle_inc;
                if (tick_expire) begin
                  session_open     <= 1'b0;
                  pend.event_res   <= ota_rx_pkg::EV_TIMEOUT;
                  pend.status      <= ota_rx_pkg::ST_TIMEOUT;
                  pend.echo_kind   <= ota_rx_pkg::KIND_BEGIN;
                  pend.ack_offset  <= '0;
                  pend.flash_abort <= 1'b1;
                  state            <= S_EMIT;
                end
              end
              ota_rx_pkg::OP_HEADER: begin
                bytes_left <= '0;
                if (!hdr_drop) begin
                  idle_ms <= '0;
                  if (rx.pkt_kind == ota_rx_pkg::KIND_BEGIN) begin
                    state <= S_EMIT;
                    if (!begin_dup) begin
                      pend.flash_abort <= session_open;
                      if (begin_fail) begin
                        session_open <= 1'b0;
                        pend.status  <= ota_rx_pkg::ST_BEGIN_FAIL;
                      end else begin
                        expected_size      <= rx.image_size;
                        expected_crc       <= rx.image_crc;
                        written_count      <= '0;
                        running_crc        <= ota_rx_pkg::CRC_PRESET;
                        session_open       <= 1'b1;
                        pend.bytes_written <= '0;
                      end
                    end
                  end else if (!session_open) begin
                    pend.status <= ota_rx_pkg::ST_NO_SESSION;
                    state       <= S_EMIT;
                  end else begin
                    priority case (rx.pkt_kind)
                      ota_rx_pkg::KIND_DATA: begin
                        if (data_dup) begin
                          state <= S_EMIT;
                        end else if (data_bad) begin
                          session_open     <= 1'b0;
                          pend.status      <= ota_rx_pkg::ST_DATA_REJ;
                          pend.flash_abort <= 1'b1;
                          state            <= S_EMIT;
                        end else begin
                          written_count      <= wr_sum[ota_rx_pkg::WORD_W-1:0];
                          pend.bytes_written <= wr_sum[ota_rx_pkg::WORD_W-1:0];
                          bytes_left         <= rx.payload_len;
                          state              <= S_DIVGO;
                        end
                      end
                      ota_rx_pkg::KIND_END: begin
                        state <= S_EMIT;
                        if (!end_ok) begin
                          session_open     <= 1'b0;
                          pend.status      <= ota_rx_pkg::ST_END_REJ;
                          pend.flash_abort <= 1'b1;
                        end else begin
                          // image good: back to the reset session
                          pend.restart  <= 1'b1;
                          session_open  <= 1'b0;
                          expected_size <= '0;
                          expected_crc  <= '0;
                          written_count <= '0;
                          running_crc   <= ota_rx_pkg::CRC_PRESET;
                        end
                      end
                      default: begin
                        // other header inside a session: only idle time and bytes_left cleared, no result
                      end
                    endcase
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_CRC: begin
          running_crc <= crc_shift;
          bit_cnt     <= bit_cnt + 1'b1;
          if (bit_cnt == 3'd7) begin
            state <= S_IDLE;
          end
        end

        S_DIVGO: begin
          state <= S_DIV;
        end

        S_DIV: begin
          if (div_rsp.done) begin
            pend.progress_level <= ota_rx_pkg::LEVEL_BASE + div_rsp.quot;
            state               <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (emit_free) begin
            out_res   <= pend;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `OTA_ASSERT_NOW(a_open_has_size, session_open, expected_size != '0,
                  "open session with zero size")
  `OTA_ASSERT_NOW(a_written_in_range, session_open, written_count <= expected_size,
                  "written count beyond image size")
  `OTA_ASSERT_NOW(a_level_range, out_valid && (out_res.progress_level != '0),
                  (out_res.progress_level >= ota_rx_pkg::LEVEL_BASE)
                  && (out_res.progress_level <= 6'd48),
                  "progress level out of range")
  `OTA_ASSERT_NEXT(a_div_flow, state == S_DIV, (state == S_DIV) || (state == S_EMIT),
                   "divider wait left without a result")

endmodule
